[sv/aef_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the audio envelope follower.
// Stand-alone package; used by audio_envelope_follower_cv.
package aef_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLED         = 3'd0;
  localparam logic [2:0] REG_ACTIVE_CHANNELS = 3'd1;
  localparam logic [2:0] REG_ATTACK_COEF     = 3'd2;
  localparam logic [2:0] REG_RELEASE_COEF    = 3'd3;
  localparam logic [2:0] REG_GAIN            = 3'd4;
  localparam logic [2:0] REG_OUT_MIN         = 3'd5;
  localparam logic [2:0] REG_OUT_MAX         = 3'd6;

  localparam int CFG_W  = 17;   // widest register
  localparam int ENV_W  = 18;   // envelope, Q2.16
  localparam int Q16_W  = 17;   // 0..1.0 in Q0.16
  localparam int MUL_N  = 17;   // multiplier bits shifted per product
  localparam int ACC_W  = 21;   // upper partial product, signed
  localparam int CNT_W  = 5;

  localparam logic [CNT_W-1:0] STEP_LAST = 5'd17;
  localparam logic [Q16_W-1:0] ONE_Q16   = 17'h10000;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ENV  = 4'b0010,
    ST_LVL  = 4'b0100,
    ST_MAP  = 4'b1000
  } state_t;

endpackage

[sv/audio_envelope_follower_cv.sv]
`timescale 1ns / 1ps
// Peak envelope follower with attack/release smoothing and a control-value map.
// Depends on aef_pkg for register indexes, widths and the sequencer state type.
//
// Usage:
//   Input channel s_*: one audio frame per beat, left and right Q1.15 samples.
//   Output channel m_*: one beat per frame, mapped cv_value and level, Q0.16.
//   Config port cfg_*: write-only, one register per cycle while cfg_we is high;
//   write only while the block is idle.
//
// Timing:
//   Every product runs on one shared shift-and-add unit that retires one
//   multiplier bit per cycle, then closes the product in a final step.
//   Three products per frame (envelope smoothing, gain, output map) run in
//   turn after the beat is taken; with the follower disabled the smoothing
//   product is skipped. The next frame is taken once the result lands in the
//   output register, so the block takes no new frame while one is in work.
//
// Reset (rst, synchronous) clears the envelope, loads the register defaults
// and empties the output register. While the receiver stalls, the result is
// held in the output register; a finished next frame waits in the sequencer
// until the output register frees up, and no further input beat is taken.
module audio_envelope_follower_cv #(
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [15:0] left_sample, [31:16] right_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // [16:0] cv_value, [33:17] level, rest zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [aef_pkg::CFG_W-1:0] cfg_data
);

  localparam int MaxCh = (CHANNELS < 2) ? CHANNELS : 2;
  localparam logic [1:0] MaxChCode = 2'(MaxCh);

  // configuration registers
  logic        enabled;
  logic [1:0]  active_channels;
  logic [15:0] attack_coef;
  logic [15:0] release_coef;
  logic [14:0] gain;
  logic [aef_pkg::Q16_W-1:0] out_min;
  logic [aef_pkg::Q16_W-1:0] out_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b1;
      active_channels <= 2'd2;
      attack_coef     <= '0;
      release_coef    <= '0;
      gain            <= 15'd256;
      out_min         <= '0;
      out_max         <= aef_pkg::ONE_Q16;
    end else if (cfg_we) begin
      case (cfg_index)
        aef_pkg::REG_ENABLED:         enabled         <= cfg_data[0];
        aef_pkg::REG_ACTIVE_CHANNELS: active_channels <= cfg_data[1:0];
        aef_pkg::REG_ATTACK_COEF:     attack_coef     <= cfg_data[15:0];
        aef_pkg::REG_RELEASE_COEF:    release_coef    <= cfg_data[15:0];
        aef_pkg::REG_GAIN:            gain            <= cfg_data[14:0];
        aef_pkg::REG_OUT_MIN:         out_min         <= cfg_data;
        aef_pkg::REG_OUT_MAX:         out_max         <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and shift-and-add unit
  aef_pkg::state_t state;
  logic [aef_pkg::CNT_W-1:0] cnt;
  logic signed [aef_pkg::ACC_W-1:0] acc_hi;     // upper partial product
  logic [aef_pkg::MUL_N-1:0]        mq;         // multiplier, low product bits
  logic signed [18:0]               mcand;      // multiplicand
  logic [aef_pkg::ENV_W-1:0]        envelope;
  logic [aef_pkg::ENV_W-1:0]        samp;       // rectified frame, Q2.16
  logic [aef_pkg::Q16_W-1:0]        level_r;

  // rectified frame sum
  logic [1:0]         nch_raw, nch;
  logic signed [16:0] frame_sum;
  logic [16:0]        frame_abs;
  logic [aef_pkg::ENV_W-1:0] frame_s;

  always_comb begin
    nch_raw = (active_channels == 2'd3) ? 2'd2 : active_channels;
    nch     = (nch_raw > MaxChCode) ? MaxChCode : nch_raw;
    frame_sum = '0;
    if (nch >= 2'd1) frame_sum = frame_sum + 17'(signed'(s_tdata[15:0]));
    if (nch >= 2'd2) frame_sum = frame_sum + 17'(signed'(s_tdata[31:16]));
    frame_abs = frame_sum[16] ? 17'(-frame_sum) : 17'(frame_sum);
    frame_s   = {frame_abs, 1'b0};
  end

  // one multiplier bit per step
  logic signed [aef_pkg::ACC_W-1:0] acc_sum;
  always_comb begin
    acc_sum = acc_hi;
    if (mq[0]) acc_sum = acc_hi + aef_pkg::ACC_W'(mcand);
  end

  // product close-out for each phase
  logic [21:0] env_sum;
  logic [aef_pkg::ENV_W-1:0] env_new;
  logic [29:0] lvl_sum;
  logic [aef_pkg::Q16_W-1:0] lvl_sat;
  logic [aef_pkg::Q16_W-1:0] lo_sat, hi_sat, d_mag;
  logic        map_down;
  logic [21:0] mag_sum;
  logic [aef_pkg::Q16_W-1:0] cv_new;

  always_comb begin
    env_sum = 22'({acc_hi, mq[16]}) + 22'(samp) + 22'(mq[15]);
    env_new = env_sum[aef_pkg::ENV_W-1:0];
    lvl_sum = 30'({acc_hi, mq[16:8]}) + 30'(mq[7]);
    lvl_sat = (lvl_sum > 30'(aef_pkg::ONE_Q16)) ? aef_pkg::ONE_Q16 : lvl_sum[16:0];
    lo_sat  = (out_min > aef_pkg::ONE_Q16) ? aef_pkg::ONE_Q16 : out_min;
    hi_sat  = (out_max > aef_pkg::ONE_Q16) ? aef_pkg::ONE_Q16 : out_max;
    map_down = hi_sat < lo_sat;
    d_mag   = map_down ? (lo_sat - hi_sat) : (hi_sat - lo_sat);
    mag_sum = 22'({acc_hi, mq[16]}) + 22'(mq[15]);
    cv_new  = map_down ? (lo_sat - mag_sum[16:0]) : (lo_sat + mag_sum[16:0]);
  end

  logic in_beat, out_free, step_end, out_load;
  assign s_tready = (state == aef_pkg::ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign step_end = (cnt == aef_pkg::STEP_LAST);
  assign out_load = (state == aef_pkg::ST_MAP) && step_end && out_free;

  logic [aef_pkg::Q16_W-1:0] cv_out, level_out;
  assign m_tdata = {6'd0, level_out, cv_out};

  // output valid: set on a fresh result, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= aef_pkg::ST_IDLE;
      cnt      <= '0;
      envelope <= '0;
    end else begin
      case (state)
        aef_pkg::ST_IDLE: begin
          if (in_beat) begin
            cnt    <= '0;
            acc_hi <= '0;
            samp   <= frame_s;
            if (enabled) begin
              // smoothing: coef*(env - s), s*65536 added at close-out
              mcand <= 19'({1'b0, envelope}) - 19'({1'b0, frame_s});
              mq    <= (frame_s > envelope) ? {1'b0, attack_coef} : {1'b0, release_coef};
              state <= aef_pkg::ST_ENV;
            end else begin
              mcand <= 19'(envelope);
              mq    <= 17'(gain);
              state <= aef_pkg::ST_LVL;
            end
          end
        end
        aef_pkg::ST_ENV: begin
          if (step_end) begin
            envelope <= env_new;
            cnt      <= '0;
            acc_hi   <= '0;
            mcand    <= 19'(env_new);
            mq       <= 17'(gain);
            state    <= aef_pkg::ST_LVL;
          end else begin
            cnt    <= cnt + 1'b1;
            acc_hi <= acc_sum >>> 1;
            mq     <= {acc_sum[0], mq[16:1]};
          end
        end
        aef_pkg::ST_LVL: begin
          if (step_end) begin
            level_r <= lvl_sat;
            cnt     <= '0;
            acc_hi  <= '0;
            mcand   <= 19'(d_mag);
            mq      <= lvl_sat;
            state   <= aef_pkg::ST_MAP;
          end else begin
            cnt    <= cnt + 1'b1;
            acc_hi <= acc_sum >>> 1;
            mq     <= {acc_sum[0], mq[16:1]};
          end
        end
        aef_pkg::ST_MAP: begin
          if (step_end) begin
            // hold the finished product until the output register frees up
            if (out_free) begin
              cv_out    <= cv_new;
              level_out <= level_r;
              state     <= aef_pkg::ST_IDLE;
            end
          end else begin
            cnt    <= cnt + 1'b1;
            acc_hi <= acc_sum >>> 1;
            mq     <= {acc_sum[0], mq[16:1]};
          end
        end
        default: state <= aef_pkg::ST_IDLE;
      endcase
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= aef_pkg::STEP_LAST)
    else $error("step counter ran past the last multiplier bit");

  a_beat_starts: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == aef_pkg::ST_ENV || state == aef_pkg::ST_LVL))
    else $error("accepted frame did not start a product");

  a_hold_env: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !enabled) |=> $stable(envelope))
    else $error("envelope changed while follower disabled");

  a_level_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> level_out <= aef_pkg::ONE_Q16)
    else $error("level above full scale");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == aef_pkg::ST_MAP)
    else $error("result presented outside output-map close-out");

endmodule
